// ===== design/pvmw_pkg.sv =====
// Package for the planar video memory write unit.
// Holds the command and sequencer types, word sizes and lane helper functions.
// No dependencies.
package pvmw_pkg;

    localparam int ADDRESS_BITS_DEF = 16;
    localparam int PLANES           = 4;
    localparam int BYTE_W           = 8;
    localparam int WORD_W           = PLANES * BYTE_W;

    typedef enum logic [2:0] {
        CMD_WRITE       = 3'd0,
        CMD_BITS_WRITE  = 3'd1,
        CMD_XOR         = 3'd2,
        CMD_OR_BITS     = 3'd3,
        CMD_PIXEL_COLOR = 3'd4,
        CMD_COPY_PLANES = 3'd5,
        CMD_COPY_BITS   = 3'd6,
        CMD_FETCH       = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_SRC,
        ST_RD_DST,
        ST_MODIFY
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_req;

    function automatic logic [WORD_W-1:0] spread_byte(input logic [BYTE_W-1:0] b);
        return {PLANES{b}};
    endfunction

    function automatic logic [WORD_W-1:0] plane_lanes(input logic [PLANES-1:0] mask);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int n = 0; n < PLANES; n++) begin
            m[n*BYTE_W +: BYTE_W] = {BYTE_W{mask[n]}};
        end
        return m;
    endfunction

endpackage

// ===== design/planar_video_memory_write_unit.sv =====
// Planar video memory write unit: sequencer, item registers and result register.
// Instantiates pvmw_mem and pvmw_merge. Depends on pvmw_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one command beat: a plane write,
//   masked merge, XOR, OR, colour write, one of two copies, or a fetch.
//   Output channel (o_valid / i_stall) carries one beat, o_read_data, for each
//   fetch only; other commands give no beat.
//   After reset the store is cleared one address per cycle, through every
//   address, with o_stall high throughout.
//   Each command runs through the single memory port: a read of the source
//   word (copies only), a read of the destination word, then the write back
//   or the fetch; o_stall is high while it runs. After ST_RD_DST and ST_MODIFY
//   the fetched byte is registered in the output register and o_valid rises.
//   The result sits in an output register, so further commands are taken
//   while it waits. A fetch that finds the register still full and stalled
//   holds in its last step until the beat is taken.
module planar_video_memory_write_unit #(
    parameter int ADDRESS_BITS = pvmw_pkg::ADDRESS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_dest_offset,
    input  logic [15:0] i_source_offset,
    input  logic [7:0]  i_source_value,
    input  logic [3:0]  i_plane_mask,
    input  logic [7:0]  i_bit_mask,
    input  logic [3:0]  i_pixel_color,
    input  logic [1:0]  i_plane_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data
);

    pvmw_pkg::t_state                r_state, n_state;
    logic [ADDRESS_BITS-1:0]         r_clr_addr, n_clr_addr;
    logic                            r_out_valid, n_out_valid;
    logic [pvmw_pkg::BYTE_W-1:0]     r_out_data, n_out_data;

    pvmw_pkg::t_cmd                  r_cmd;
    logic [ADDRESS_BITS-1:0]         r_dst;
    logic [ADDRESS_BITS-1:0]         r_src;
    logic [pvmw_pkg::BYTE_W-1:0]     r_val;
    logic [pvmw_pkg::PLANES-1:0]     r_pmask;
    logic [pvmw_pkg::BYTE_W-1:0]     r_bmask;
    logic [pvmw_pkg::PLANES-1:0]     r_color;
    logic [1:0]                      r_pnum;
    logic [pvmw_pkg::WORD_W-1:0]     r_from;

    logic                            load_item;
    pvmw_pkg::t_mem_req              mem_req;
    logic [ADDRESS_BITS-1:0]         mem_addr;
    logic [pvmw_pkg::WORD_W-1:0]     mem_wdata;
    logic [pvmw_pkg::WORD_W-1:0]     mem_rdata;
    logic [pvmw_pkg::WORD_W-1:0]     merged;
    logic [pvmw_pkg::BYTE_W-1:0]     fetched;
    pvmw_pkg::t_cmd                  in_cmd;

    assign in_cmd = pvmw_pkg::t_cmd'(i_command);

    pvmw_mem #(
        .ADDR_W (ADDRESS_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    pvmw_merge u_merge (
        .i_cmd   (r_cmd),
        .i_old   (mem_rdata),
        .i_from  (r_from),
        .i_val   (r_val),
        .i_pmask (r_pmask),
        .i_bmask (r_bmask),
        .i_color (r_color),
        .i_pnum  (r_pnum),
        .o_new   (merged),
        .o_fetch (fetched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pvmw_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (load_item) begin
            r_cmd   <= in_cmd;
            r_dst   <= i_dest_offset[ADDRESS_BITS-1:0];
            r_src   <= i_source_offset[ADDRESS_BITS-1:0];
            r_val   <= i_source_value;
            r_pmask <= i_plane_mask;
            r_bmask <= i_bit_mask;
            r_color <= i_pixel_color;
            r_pnum  <= i_plane_number;
        end
        if (r_state == pvmw_pkg::ST_RD_DST) begin
            r_from <= mem_rdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid & i_stall;
        n_out_data  = r_out_data;
        load_item   = 1'b0;
        mem_req     = '0;
        mem_addr    = r_dst;
        mem_wdata   = merged;
        case (r_state)
            pvmw_pkg::ST_CLEAR: begin
                mem_req.we = 1'b1;
                mem_addr   = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {ADDRESS_BITS{1'b1}}) begin
                    n_state = pvmw_pkg::ST_IDLE;
                end
            end
            pvmw_pkg::ST_IDLE: begin
                if (i_valid) begin
                    load_item = 1'b1;
                    if (in_cmd inside {pvmw_pkg::CMD_COPY_PLANES, pvmw_pkg::CMD_COPY_BITS}) begin
                        n_state = pvmw_pkg::ST_RD_SRC;
                    end else begin
                        n_state = pvmw_pkg::ST_RD_DST;
                    end
                end
            end
            pvmw_pkg::ST_RD_SRC: begin
                mem_req.re = 1'b1;
                mem_addr   = r_src;
                n_state    = pvmw_pkg::ST_RD_DST;
            end
            pvmw_pkg::ST_RD_DST: begin
                mem_req.re = 1'b1;
                n_state    = pvmw_pkg::ST_MODIFY;
            end
            pvmw_pkg::ST_MODIFY: begin
                if (r_cmd == pvmw_pkg::CMD_FETCH) begin
                    if (!r_out_valid || !i_stall) begin
                        n_out_valid = 1'b1;
                        n_out_data  = fetched;
                        n_state     = pvmw_pkg::ST_IDLE;
                    end
                end else begin
                    mem_req.we = 1'b1;
                    n_state    = pvmw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pvmw_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stall     = (r_state != pvmw_pkg::ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

`ifndef SYNTHESIS
    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.we && mem_req.re))
        else $error("memory read and write in the same cycle");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pvmw_pkg::ST_CLEAR) |-> !r_out_valid)
        else $error("result beat during clearing pass");

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=>
            (r_state == pvmw_pkg::ST_RD_SRC || r_state == pvmw_pkg::ST_RD_DST))
        else $error("accepted beat did not start a read");

    a_write_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pvmw_pkg::ST_MODIFY && r_cmd != pvmw_pkg::CMD_FETCH) |=>
            (r_state == pvmw_pkg::ST_IDLE))
        else $error("write command did not finish in one step");
`endif

endmodule

// ===== design/pvmw_mem.sv =====
// Plane store: one word per address, one byte per plane.
// Single port, registered read data. Depends on pvmw_pkg.
module pvmw_mem #(
    parameter int ADDR_W = pvmw_pkg::ADDRESS_BITS_DEF
) (
    input  logic                      i_clk,
    input  pvmw_pkg::t_mem_req        i_req,
    input  logic [ADDR_W-1:0]         i_addr,
    input  logic [pvmw_pkg::WORD_W-1:0] i_wdata,
    output logic [pvmw_pkg::WORD_W-1:0] o_rdata
);

    logic [pvmw_pkg::WORD_W-1:0] r_mem [2**ADDR_W];
    logic [pvmw_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pvmw_merge.sv =====
// Shared byte-lane merge unit: builds the new plane word for each command
// and selects the fetched plane byte. Depends on pvmw_pkg.
module pvmw_merge (
    input  pvmw_pkg::t_cmd                 i_cmd,
    input  logic [pvmw_pkg::WORD_W-1:0]    i_old,
    input  logic [pvmw_pkg::WORD_W-1:0]    i_from,
    input  logic [pvmw_pkg::BYTE_W-1:0]    i_val,
    input  logic [pvmw_pkg::PLANES-1:0]    i_pmask,
    input  logic [pvmw_pkg::BYTE_W-1:0]    i_bmask,
    input  logic [pvmw_pkg::PLANES-1:0]    i_color,
    input  logic [1:0]                     i_pnum,
    output logic [pvmw_pkg::WORD_W-1:0]    o_new,
    output logic [pvmw_pkg::BYTE_W-1:0]    o_fetch
);

    logic [pvmw_pkg::WORD_W-1:0] spread;
    logic [pvmw_pkg::WORD_W-1:0] lanes;
    logic [pvmw_pkg::WORD_W-1:0] bits;
    logic [pvmw_pkg::WORD_W-1:0] cbits;

    assign spread = pvmw_pkg::spread_byte(i_val);
    assign lanes  = pvmw_pkg::plane_lanes(i_pmask);
    assign bits   = pvmw_pkg::spread_byte(i_bmask);
    assign cbits  = pvmw_pkg::plane_lanes(i_color);

    always_comb begin
        case (i_cmd)
            pvmw_pkg::CMD_WRITE:       o_new = (i_old & ~lanes) | (spread & lanes);
            pvmw_pkg::CMD_BITS_WRITE:  o_new = (i_old & ~bits) | (spread & bits);
            pvmw_pkg::CMD_XOR:         o_new = i_old ^ (spread & lanes);
            pvmw_pkg::CMD_OR_BITS:     o_new = i_old | pvmw_pkg::spread_byte(i_val & i_bmask);
            pvmw_pkg::CMD_PIXEL_COLOR: o_new = (i_old & ~bits) | (cbits & bits);
            pvmw_pkg::CMD_COPY_PLANES: o_new = (i_old & ~lanes) | (i_from & lanes);
            pvmw_pkg::CMD_COPY_BITS:   o_new = (i_old & ~bits) | (i_from & bits);
            default:                   o_new = i_old;
        endcase
    end

    assign o_fetch = i_old[{i_pnum, 3'b000} +: pvmw_pkg::BYTE_W];

endmodule
